[rtl/core/rett_pkg.sv]
package rett_pkg;

  // Table geometry
  localparam int unsigned SLOTS      = 16;
  localparam int unsigned SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned RESULT_CAP = 16;
  localparam int unsigned CNT_W      = $clog2(RESULT_CAP + 1);

  // Field widths
  localparam int unsigned TIME_W = 32;
  localparam int unsigned ID_W   = 32;
  localparam int unsigned REP_W  = 17;

  // Stream payload widths
  localparam int unsigned IN_DATA_W  = 120;
  localparam int unsigned OUT_DATA_W = 40;

  // Repeat count that never runs out (-1 in 17 bits)
  localparam logic [REP_W-1:0] REP_FOREVER = {REP_W{1'b1}};
  localparam logic [REP_W-1:0] REP_LAST    = '0;

  // Input item kinds
  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_ADDED = 2'd0,
    ST_FULL  = 2'd1,
    ST_FIRED = 2'd2,
    ST_IDLE  = 2'd3
  } status_e;

endpackage

[rtl/core/repeating_event_timer_table_unit.sv]
// Sequence: an add gives its result from S_ADD once the output register is free;
// a tick walks every slot once through one shared compare/add unit in S_SCAN,
// then closes in S_FLUSH, and takes longer while the output is stalled.
// Throughput: one item at a time; the next item is taken once the previous one
// has handed its last result to the output register.
// Reset: all slots free, event counter zero, no result pending.
module repeating_event_timer_table_unit import rett_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // now_time[31:0], first_due[63:32], period[95:64], repeat_count[112:96], zero fill
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // op[0]
  input  logic                  s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // event_id[31:0], finished[32], zero fill
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  // status[1:0]
  output logic [1:0]            m_axis_tuser_o,
  output logic                  m_axis_tlast_o
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ADD   = 4'b0010,
    S_SCAN  = 4'b0100,
    S_FLUSH = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Held input item
  logic [TIME_W-1:0] now_q, first_q, period_q;
  logic [REP_W-1:0]  rep_q;

  // Slot table
  logic [SLOTS-1:0]  slot_valid_q, slot_valid_d;
  logic [TIME_W-1:0] due_q    [SLOTS];
  logic [TIME_W-1:0] per_q    [SLOTS];
  logic [REP_W-1:0]  rep_left_q [SLOTS];
  logic [ID_W-1:0]   ev_id_q  [SLOTS];
  logic [ID_W-1:0]   id_counter_q, id_counter_d;

  // Scan control
  logic [SLOT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0]  fire_cnt_q, fire_cnt_d;
  logic              pend_valid_q, pend_valid_d;
  logic [ID_W-1:0]   pend_id_q, pend_id_d;
  logic              pend_fin_q, pend_fin_d;

  // Output register
  logic              out_valid_q;
  status_e           out_status_q, out_status_d;
  logic [ID_W-1:0]   out_id_q, out_id_d;
  logic              out_fin_q, out_fin_d;
  logic              out_last_q, out_last_d;
  logic              out_load, out_free;

  logic              in_acc;
  logic              add_we, scan_we;
  logic              free_found;
  logic [SLOT_W-1:0] free_idx;
  logic              hit, last_fire;
  logic [TIME_W-1:0] due_next;
  logic [REP_W-1:0]  rep_cur, rep_next;

  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign out_free        = !out_valid_q || m_axis_tready_i;

  // Find the lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!slot_valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  // Shared compare and add unit on the scanned slot
  assign rep_cur   = rep_left_q[idx_q];
  assign hit       = slot_valid_q[idx_q] && (now_q >= due_q[idx_q])
                     && (fire_cnt_q < CNT_W'(RESULT_CAP));
  assign due_next  = due_q[idx_q] + per_q[idx_q];
  assign last_fire = (rep_cur == REP_LAST);
  assign rep_next  = (rep_cur == REP_FOREVER || last_fire) ? rep_cur : rep_cur - 1'b1;

  // Sequencer
  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    fire_cnt_d   = fire_cnt_q;
    pend_valid_d = pend_valid_q;
    pend_id_d    = pend_id_q;
    pend_fin_d   = pend_fin_q;
    slot_valid_d = slot_valid_q;
    id_counter_d = id_counter_q;
    add_we       = 1'b0;
    scan_we      = 1'b0;
    out_load     = 1'b0;
    out_status_d = ST_IDLE;
    out_id_d     = '0;
    out_fin_d    = 1'b0;
    out_last_d   = 1'b1;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d      = (s_axis_tuser_i == OP_ADD) ? S_ADD : S_SCAN;
          idx_d        = '0;
          fire_cnt_d   = '0;
          pend_valid_d = 1'b0;
        end
      end
      S_ADD: begin
        if (out_free) begin
          out_load = 1'b1;
          if (free_found) begin
            id_counter_d           = id_counter_q + 1'b1;
            slot_valid_d[free_idx] = 1'b1;
            add_we                 = 1'b1;
            out_status_d           = ST_ADDED;
            out_id_d               = id_counter_d;
          end else begin
            out_status_d = ST_FULL;
          end
          state_d = S_IDLE;
        end
      end
      S_SCAN: begin
        // Hold the scan while a new firing would push out a pending one
        if (!(hit && pend_valid_q && !out_free)) begin
          if (hit) begin
            scan_we    = 1'b1;
            fire_cnt_d = fire_cnt_q + 1'b1;
            if (last_fire) begin
              slot_valid_d[idx_q] = 1'b0;
            end
            if (pend_valid_q) begin
              out_load     = 1'b1;
              out_status_d = ST_FIRED;
              out_id_d     = pend_id_q;
              out_fin_d    = pend_fin_q;
              out_last_d   = 1'b0;
            end
            pend_valid_d = 1'b1;
            pend_id_d    = ev_id_q[idx_q];
            pend_fin_d   = last_fire;
          end
          if (idx_q == SLOT_W'(SLOTS - 1)) begin
            state_d = S_FLUSH;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      S_FLUSH: begin
        // Close the tick with the pending firing or an idle result
        if (out_free) begin
          out_load = 1'b1;
          if (pend_valid_q) begin
            out_status_d = ST_FIRED;
            out_id_d     = pend_id_q;
            out_fin_d    = pend_fin_q;
          end
          pend_valid_d = 1'b0;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      idx_q        <= '0;
      fire_cnt_q   <= '0;
      pend_valid_q <= 1'b0;
      slot_valid_q <= '0;
      id_counter_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      fire_cnt_q   <= fire_cnt_d;
      pend_valid_q <= pend_valid_d;
      slot_valid_q <= slot_valid_d;
      id_counter_q <= id_counter_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture the input item
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      now_q    <= s_axis_tdata_i[31:0];
      first_q  <= s_axis_tdata_i[63:32];
      period_q <= s_axis_tdata_i[95:64];
      rep_q    <= s_axis_tdata_i[112:96];
    end
  end

  // Write slot entries on add and on firing
  always_ff @(posedge clk_i) begin
    if (add_we) begin
      due_q[free_idx]      <= first_q;
      per_q[free_idx]      <= period_q;
      rep_left_q[free_idx] <= rep_q;
      ev_id_q[free_idx]    <= id_counter_d;
    end else if (scan_we) begin
      due_q[idx_q]      <= due_next;
      rep_left_q[idx_q] <= rep_next;
    end
  end

  // Pending firing and output payload
  always_ff @(posedge clk_i) begin
    pend_id_q  <= pend_id_d;
    pend_fin_q <= pend_fin_d;
    if (out_load) begin
      out_status_q <= out_status_d;
      out_id_q     <= out_id_d;
      out_fin_q    <= out_fin_d;
      out_last_q   <= out_last_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OUT_DATA_W - ID_W - 1){1'b0}}, out_fin_q, out_id_q};
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule
